### design/zrbd_pkg.sv
// Shared types and constants for the zero-run bit-vector decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package zrbd_pkg;

  localparam int DEFAULT_MAX_CLUSTERS = 2048;
  localparam int NUM_CLUSTERS_W       = 12;
  localparam int MAX_RESULTS          = 32;
  localparam int WC_W                 = $clog2(MAX_RESULTS + 1);
  localparam int WORD_BYTES           = 8;

  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_FILL_ONES  = 2'd1;
  localparam logic [1:0] OP_FILL_ZEROS = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] compressed_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [63:0] decoded_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        overrun;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_start;
    logic run_end;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/zrbd_ctrl.sv
// Controller state machine of the zero-run bit-vector decoder.
// Depends on zrbd_pkg for the command and status structs.
`default_nettype none

module zrbd_ctrl import zrbd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.run_start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.run_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/zrbd_dp.sv
// Datapath of the zero-run bit-vector decoder: length register, vector state,
// byte packer and output register. Depends on zrbd_pkg.
`default_nettype none

module zrbd_dp import zrbd_pkg::*; #(
  parameter int MAX_CLUSTERS = DEFAULT_MAX_CLUSTERS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic [NUM_CLUSTERS_W-1:0] cfg_num_clusters,
  input  wire in_item_t                  in_item,
  input  wire dp_cmd_t                   cmd,
  output dp_sts_t                        sts,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output out_item_t                      out_item
);

  localparam int CLOG_MAX = $clog2(MAX_CLUSTERS + 1);
  localparam int SAT_W    = (NUM_CLUSTERS_W > CLOG_MAX) ? NUM_CLUSTERS_W : CLOG_MAX;
  localparam int LEN_MAX  = (MAX_CLUSTERS + 7) / 8;
  localparam int POS_W    = $clog2(LEN_MAX + 1);
  localparam int REM_W    = (POS_W > 8) ? POS_W : 8;

  // Vector length in bytes, derived once per register write.
  logic [SAT_W-1:0] nc_ext, nc_sat;
  logic [SAT_W:0]   nc_round;
  logic [POS_W-1:0] len_r, len_nxt;

  assign nc_ext   = SAT_W'(cfg_num_clusters);
  assign nc_sat   = (nc_ext > SAT_W'(MAX_CLUSTERS)) ? SAT_W'(MAX_CLUSTERS) : nc_ext;
  assign nc_round = {1'b0, nc_sat} + (SAT_W + 1)'(7);
  assign len_nxt  = cfg_valid ? POS_W'(nc_round >> 3) : len_r;

  logic [55:0]      buf_r, buf_nxt;
  logic [2:0]       pc_r, pc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             await_r, await_nxt;
  logic             done_r, done_nxt;
  logic             ovr_r, ovr_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       val_r, val_nxt;
  logic [WC_W-1:0]  wc_r, wc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  // Load decode.
  logic             is_fill, take_byte, clr;
  logic [POS_W-1:0] pos_b;
  logic [2:0]       pc_b;
  logic             await_b;
  logic [REM_W-1:0] room, byte_ext;

  assign is_fill   = (in_item.op == OP_FILL_ONES) || (in_item.op == OP_FILL_ZEROS);
  assign take_byte = (in_item.op == OP_BYTE) && (in_item.first || !done_r);
  assign clr       = is_fill || in_item.first;
  assign pos_b     = clr ? '0 : pos_r;
  assign pc_b      = clr ? '0 : pc_r;
  assign await_b   = clr ? 1'b0 : await_r;
  assign room      = REM_W'(len_r) - REM_W'(pos_b);
  assign byte_ext  = REM_W'(in_item.compressed_byte);

  // One packing step: k bytes of val_r go in at byte lanes pc_r and up.
  logic [3:0]       space, k, pcn;
  logic [POS_W:0]   posk;
  logic             at_end, emit, emit_out, step_go;
  logic [7:0]       lane_en;
  logic [63:0]      lane_mask, word;

  assign space    = 4'(WORD_BYTES) - {1'b0, pc_r};
  assign k        = (rem_r < REM_W'(space)) ? rem_r[3:0] : space;
  assign pcn      = {1'b0, pc_r} + k;
  assign posk     = {1'b0, pos_r} + (POS_W + 1)'(k);
  assign at_end   = posk >= {1'b0, len_r};
  // A step with no bytes only happens when flushing a partial word.
  assign emit     = (pcn != 4'd0) && ((pcn == 4'(WORD_BYTES)) || at_end);
  assign emit_out = emit && (wc_r < WC_W'(MAX_RESULTS));
  assign step_go  = cmd.step && (!emit_out || !out_valid_r || out_ready);

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      lane_en[i]          = (4'(i) >= {1'b0, pc_r}) && (4'(i) < pcn);
      lane_mask[8*i +: 8] = {8{lane_en[i]}};
    end
  end

  assign word = {8'h00, buf_r} | ({WORD_BYTES{val_r}} & lane_mask);

  always_comb begin
    buf_nxt       = buf_r;
    pc_nxt        = pc_r;
    pos_nxt       = pos_r;
    await_nxt     = await_r;
    done_nxt      = done_r;
    ovr_nxt       = ovr_r;
    rem_nxt       = rem_r;
    val_nxt       = val_r;
    wc_nxt        = wc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    sts.run_start = 1'b0;
    sts.run_end   = 1'b0;

    if (cmd.load) begin
      wc_nxt = '0;
      if (is_fill) begin
        buf_nxt       = '0;
        pc_nxt        = '0;
        pos_nxt       = '0;
        await_nxt     = 1'b0;
        ovr_nxt       = 1'b0;
        done_nxt      = 1'b1;
        rem_nxt       = REM_W'(len_r);
        val_nxt       = (in_item.op == OP_FILL_ONES) ? 8'hff : 8'h00;
        sts.run_start = (len_r != '0);
      end else if (take_byte) begin
        if (in_item.first) begin
          buf_nxt   = '0;
          pc_nxt    = '0;
          pos_nxt   = '0;
          await_nxt = 1'b0;
          ovr_nxt   = 1'b0;
          done_nxt  = 1'b0;
        end
        if (pos_b >= len_r) begin
          // Length shrank under the vector: flush what is pending and stop.
          done_nxt      = 1'b1;
          await_nxt     = 1'b0;
          rem_nxt       = '0;
          sts.run_start = (pc_b != '0);
        end else if (await_b) begin
          val_nxt   = 8'h00;
          await_nxt = 1'b0;
          if (byte_ext > room) begin
            rem_nxt = room;
            ovr_nxt = 1'b1;
          end else begin
            rem_nxt = byte_ext;
          end
          if (byte_ext >= room) done_nxt = 1'b1;
          sts.run_start = (in_item.compressed_byte != 8'h00);
        end else if (in_item.compressed_byte != 8'h00) begin
          rem_nxt       = REM_W'(1);
          val_nxt       = in_item.compressed_byte;
          done_nxt      = ({1'b0, pos_b} + (POS_W + 1)'(1)) >= {1'b0, len_r};
          sts.run_start = 1'b1;
        end else begin
          await_nxt = 1'b1;
        end
      end
    end else if (step_go) begin
      pos_nxt     = posk[POS_W-1:0];
      rem_nxt     = rem_r - REM_W'(k);
      sts.run_end = (rem_r == REM_W'(k));
      if (emit) begin
        buf_nxt = '0;
        pc_nxt  = '0;
      end else begin
        buf_nxt = word[55:0];
        pc_nxt  = pcn[2:0];
      end
      if (emit_out) begin
        wc_nxt                    = wc_r + WC_W'(1);
        out_valid_nxt             = 1'b1;
        out_item_nxt.decoded_word = word;
        out_item_nxt.valid_bytes  = pcn;
        out_item_nxt.last_word    = at_end;
        out_item_nxt.overrun      = ovr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      buf_r       <= '0;
      pc_r        <= '0;
      pos_r       <= '0;
      await_r     <= 1'b0;
      done_r      <= 1'b1;
      ovr_r       <= 1'b0;
      rem_r       <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      buf_r       <= buf_nxt;
      pc_r        <= pc_nxt;
      pos_r       <= pos_nxt;
      await_r     <= await_nxt;
      done_r      <= done_nxt;
      ovr_r       <= ovr_nxt;
      rem_r       <= rem_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### design/zero_run_bitvector_decoder.sv
// Top level of the zero-run bit-vector decoder: controller plus datapath.
// Depends on zrbd_pkg, zrbd_ctrl and zrbd_dp.
//
//   port group   dir  payload                       transfer
//   in_*         in   in_item_t (op, byte, first)   in_valid & in_ready
//   out_*        out  out_item_t (word, count, ..)  out_valid & out_ready
//   cfg_*        in   num_clusters, 12 bits         cfg_valid & cfg_ready
//
// An input beat is taken only while the block is idle. A nonzero byte, a flush of
// pending bytes, a zero run or a fill then runs packer steps, and no new beat is taken
// until the last of them: one packer step per cycle while the output register can
// take a word, each step moving as many of the remaining bytes as fit in the current
// word. A byte that starts a run, a zero count or an ignored beat needs no step.
// A step that yields a word waits while the output register is still full.
// Reset is synchronous and leaves the block idle with no vector in progress.
// cfg_ready is always high; the length is computed in the write cycle.
`default_nettype none

module zero_run_bitvector_decoder import zrbd_pkg::*; #(
  parameter int MAX_CLUSTERS = DEFAULT_MAX_CLUSTERS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [NUM_CLUSTERS_W-1:0] cfg_num_clusters,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire in_item_t                  in_item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output out_item_t                      out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  zrbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zrbd_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_num_clusters (cfg_num_clusters),
    .in_item          (in_item),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

endmodule

`default_nettype wire

### bench/tb_zero_run_bitvector_decoder.sv
// Testbench for zero_run_bitvector_decoder: directed and random compressed streams,
// checked word by word against a behavioral decoder kept inside the bench.
// Depends on zrbd_pkg and the design files only.
module tb_zero_run_bitvector_decoder;
  import zrbd_pkg::*;

  localparam int         MAX_CL        = DEFAULT_MAX_CLUSTERS;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         DRAIN_LIMIT   = 20000;
  localparam int         LONG_HOLD     = 300;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [NUM_CLUSTERS_W-1:0] cfg_num_clusters = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item          = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  out_item_t                 out_item;

  always #6 clk = ~clk;

  zero_run_bitvector_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_num_clusters (cfg_num_clusters),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

  // Decoder state as the bench tracks it.
  int          cluster_cfg = 0;
  logic [55:0] pack_bits   = '0;
  int          pack_cnt    = 0;
  int          emit_pos    = 0;
  bit          want_count  = 1'b0;
  bit          vec_done    = 1'b1;
  bit          run_clamped = 1'b0;

  out_item_t   expected_words[$];
  out_item_t   want;

  int errors        = 0;
  int words_checked = 0;
  int items_sent    = 0;
  int cfg_writes    = 0;
  bit calm          = 1'b0;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  function automatic int vector_bytes();
    int n;
    n = (cluster_cfg > MAX_CL) ? MAX_CL : cluster_cfg;
    return (n + 7) / 8;
  endfunction

  function automatic void queue_word(logic [63:0] w, int cnt, bit is_last);
    out_item_t e;
    e.decoded_word = w;
    e.valid_bytes  = 4'(cnt);
    e.last_word    = is_last;
    e.overrun      = run_clamped;
    expected_words.push_back(e);
  endfunction

  function automatic void pack_byte(logic [7:0] b, int len);
    logic [63:0] w;
    w = {8'h00, pack_bits} | ({56'h0, b} << (8 * pack_cnt));
    pack_cnt++;
    emit_pos++;
    if (pack_cnt >= WORD_BYTES || emit_pos >= len) begin
      queue_word(w, pack_cnt, emit_pos >= len);
      pack_bits = '0;
      pack_cnt  = 0;
    end else begin
      pack_bits = w[55:0];
    end
  endfunction

  function automatic void start_vector();
    pack_bits   = '0;
    pack_cnt    = 0;
    emit_pos    = 0;
    want_count  = 1'b0;
    run_clamped = 1'b0;
  endfunction

  // Works out the words that one accepted input beat produces.
  function automatic void decode_beat(in_item_t it);
    int len;
    int room;
    int c;
    len = vector_bytes();
    if (it.op == OP_FILL_ONES || it.op == OP_FILL_ZEROS) begin
      start_vector();
      repeat (len) pack_byte((it.op == OP_FILL_ONES) ? 8'hff : 8'h00, len);
      vec_done = 1'b1;
      return;
    end
    if (it.op != OP_BYTE) return;
    if (it.first) begin
      start_vector();
      vec_done = 1'b0;
    end else if (vec_done) begin
      return;
    end
    // The length may have shrunk below what was already emitted.
    if (emit_pos >= len) begin
      if (pack_cnt > 0) queue_word({8'h00, pack_bits}, pack_cnt, 1'b1);
      pack_bits  = '0;
      pack_cnt   = 0;
      vec_done   = 1'b1;
      want_count = 1'b0;
      return;
    end
    if (want_count) begin
      c    = int'(it.compressed_byte);
      room = len - emit_pos;
      if (c > room) begin
        c           = room;
        run_clamped = 1'b1;
      end
      repeat (c) pack_byte(8'h00, len);
      want_count = 1'b0;
    end else if (it.compressed_byte != 8'h00) begin
      pack_byte(it.compressed_byte, len);
    end else begin
      want_count = 1'b1;
    end
    if (emit_pos >= len) begin
      vec_done   = 1'b1;
      want_count = 1'b0;
    end
  endfunction

  // Result side: checks each accepted beat and drives out_ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, actual %h/%0d/%b/%b", $time,
                 out_item.decoded_word, out_item.valid_bytes, out_item.last_word,
                 out_item.overrun);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_item.decoded_word !== want.decoded_word) begin
          errors++;
          $display("%0t: decoded_word expected %h actual %h", $time,
                   want.decoded_word, out_item.decoded_word);
        end
        if (out_item.valid_bytes !== want.valid_bytes) begin
          errors++;
          $display("%0t: valid_bytes expected %0d actual %0d", $time,
                   want.valid_bytes, out_item.valid_bytes);
        end
        if (out_item.last_word !== want.last_word) begin
          errors++;
          $display("%0t: last_word expected %b actual %b", $time,
                   want.last_word, out_item.last_word);
        end
        if (out_item.overrun !== want.overrun) begin
          errors++;
          $display("%0t: overrun expected %b actual %b", $time,
                   want.overrun, out_item.overrun);
        end
      end
    end
    if (hold_reqs != holds_done) begin
      hold_left  = LONG_HOLD;
      holds_done = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic first);
    in_item_t it;
    int       gap;
    it.op              = op;
    it.compressed_byte = b;
    it.first           = first;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    decode_beat(it);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived, next %h", $time,
               expected_words.size(), expected_words[0].decoded_word);
      expected_words.delete();
    end
  endtask

  // Brings the block to rest: no beat offered, all words out, packer quiet.
  task automatic settle();
    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clusters(input int n);
    settle();
    cfg_valid        <= 1'b1;
    cfg_num_clusters <= n[NUM_CLUSTERS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cluster_cfg = n;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // One well-formed vector with random content, plus a little noise.
  task automatic random_vector(input int max_beats);
    int beats;
    int pick;
    int room;
    int c;
    int r;
    if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, 8'h00, 1'b1);
    else send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
    beats = 1;
    while (!vec_done && beats < max_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_item(OP_BYTE, 8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 93) begin
        send_item(OP_BYTE, 8'h00, 1'b0);
        room = vector_bytes() - emit_pos;
        r    = $urandom_range(0, 9);
        if (r == 0) c = 0;
        else if (r <= 6) c = $urandom_range(1, (room > 0) ? room : 1);
        else if (r <= 8) c = room + $urandom_range(1, 3);
        else c = 255;
        if (c > 255) c = 255;
        send_item(OP_BYTE, 8'(c), 1'b0);
        beats++;
      end else if (pick < 96) begin
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 98) begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_item($urandom_range(0, 1) ? OP_FILL_ONES : OP_FILL_ZEROS,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      beats++;
    end
    // Bytes without a start marker after completion must be dropped.
    if (vec_done && $urandom_range(0, 4) == 0)
      send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_directed();
    write_clusters(4095);
    send_item(OP_FILL_ONES, 8'h00, 1'b0);
    send_item(OP_FILL_ZEROS, 8'hff, 1'b1);
    write_clusters(0);
    send_item(OP_FILL_ONES, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h5a, 1'b1);
    write_clusters(20);
    send_item(OP_BYTE, 8'hff, 1'b1);
    send_item(OP_BYTE, 8'h01, 1'b0);
    send_item(OP_BYTE, 8'h80, 1'b0);
    send_item(OP_BYTE, 8'h33, 1'b0);
    send_item(OP_UNUSED, 8'hff, 1'b1);
    // Zero count, then a run far past the end of a nine-byte vector.
    write_clusters(72);
    send_item(OP_BYTE, 8'h00, 1'b1);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hc8, 1'b0);
    send_item(OP_BYTE, 8'h12, 1'b1);
    send_item(OP_BYTE, 8'h34, 1'b0);
    send_item(OP_FILL_ZEROS, 8'h00, 1'b0);
    // A restart drops the partial word; shrinking the length then forces a flush.
    write_clusters(80);
    send_item(OP_BYTE, 8'h11, 1'b1);
    send_item(OP_BYTE, 8'h22, 1'b0);
    send_item(OP_BYTE, 8'h33, 1'b1);
    send_item(OP_BYTE, 8'h44, 1'b0);
    send_item(OP_BYTE, 8'h55, 1'b0);
    write_clusters(16);
    send_item(OP_BYTE, 8'h66, 1'b0);
    write_clusters(1);
    send_item(OP_BYTE, 8'h00, 1'b1);
    send_item(OP_BYTE, 8'h01, 1'b0);
  endtask

  task automatic test_backpressure();
    int k;
    write_clusters(2048);
    hold_reqs++;
    send_item(OP_FILL_ONES, 8'h00, 1'b0);
    send_item(OP_FILL_ZEROS, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b1);
    send_item(OP_BYTE, 8'hff, 1'b0);
    for (k = 0; k < 20; k++) send_item(OP_BYTE, 8'($urandom_range(1, 255)), 1'b0);
    settle();
  endtask

  task automatic test_random_streams(input int target);
    int extremes[8];
    int r;
    int nvec;
    extremes = '{0, 1, 8, 9, 2047, 2048, 2049, 4095};
    while (items_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 6) write_clusters($urandom_range(1, 200));
      else if (r == 6) write_clusters(extremes[$urandom_range(0, 7)]);
      else if (r == 7) write_clusters($urandom_range(0, 4095));
      nvec = $urandom_range(1, 4);
      repeat (nvec) random_vector($urandom_range(4, 40));
    end
  endtask

  // Last part: both sides at full rate.
  task automatic test_full_rate(input int target);
    settle();
    calm = 1'b1;
    while (items_sent < target) begin
      write_clusters($urandom_range(1, 160));
      repeat (3) random_vector(40);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_streams(380);
    test_full_rate(450);
    settle();
    $display("Sent %0d input beats across %0d length settings; checked %0d words.",
             items_sent, cfg_writes, words_checked);
    $display("Fills, clamped and empty runs, restarts, shrinks and a long stall covered.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #18000000;
    $display("Timed out with %0d words still expected.", expected_words.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
